[rtl/accel_reference_tilt_angles_macros.svh]
// Assertion macros for the checker file of the tilt angle block.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef ACCEL_REFERENCE_TILT_ANGLES_MACROS_SVH
`define ACCEL_REFERENCE_TILT_ANGLES_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TILT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilt checker: assertion failed");

// Next-cycle implication, disabled during reset.
`define TILT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tilt checker: assertion failed");

`endif

[rtl/tilt_pkg.sv]
// Package of the tilt angle block: widths, codes, the arctangent table and
// the response structs of the shared arithmetic units. No dependencies.
package tilt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CSTEP_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int ACC_W  = 16;
  localparam int ANG_W  = 16;
  localparam int SQ_W   = 31;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;
  localparam int CIN_W  = 25;
  localparam int CX_W   = 28;
  localparam int CZ_W   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_NEG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_NEG = 3'd4;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_GRAV   = 2'd1;
  localparam logic [1:0] MODE_ORIENT = 2'd2;

  // Quarter turn in centidegrees scaled by 2^16; angle limit in plain centidegrees.
  localparam logic signed [CZ_W-1:0] Z_QUARTER = 32'sd589824000;
  localparam logic signed [CZ_W-1:0] ANG_LIMIT = 32'sd18000;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } cordic_rsp_t;

  // atan(2^-i) in centidegrees scaled by 2^16.
  function automatic logic signed [CZ_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      5'd0:    v = 32'sd294912000;
      5'd1:    v = 32'sd174096719;
      5'd2:    v = 32'sd91987925;
      5'd3:    v = 32'sd46694507;
      5'd4:    v = 32'sd23437865;
      5'd5:    v = 32'sd11730358;
      5'd6:    v = 32'sd5866610;
      5'd7:    v = 32'sd2933484;
      5'd8:    v = 32'sd1466764;
      5'd9:    v = 32'sd733385;
      5'd10:   v = 32'sd366693;
      5'd11:   v = 32'sd183346;
      5'd12:   v = 32'sd91673;
      5'd13:   v = 32'sd45837;
      5'd14:   v = 32'sd22918;
      5'd15:   v = 32'sd11459;
      5'd16:   v = 32'sd5730;
      5'd17:   v = 32'sd2865;
      5'd18:   v = 32'sd1432;
      5'd19:   v = 32'sd716;
      5'd20:   v = 32'sd358;
      5'd21:   v = 32'sd179;
      5'd22:   v = 32'sd90;
      5'd23:   v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tilt_if.sv]
// Valid/ready channel interfaces for the accelerometer vector and the angle result.
// Depends on tilt_pkg.
interface tilt_in_if import tilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic signed [ACC_W-1:0] accel_z;
  modport source(output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink(input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface tilt_out_if import tilt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_x;
  logic signed [ANG_W-1:0] angle_y;
  logic signed [ANG_W-1:0] angle_z;
  logic [1:0]              mode;
  logic                    status;
  modport source(output valid, output angle_x, output angle_y, output angle_z,
                 output mode, output status, input ready);
  modport sink(input valid, input angle_x, input angle_y, input angle_z,
               input mode, input status, output ready);
endinterface

[rtl/tilt_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on tilt_pkg.
module tilt_sqrt import tilt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [RAD_W-1:0] radicand,
  output sqrt_rsp_t        rsp
);

  logic             busy_r;
  logic             done_r;
  logic [RAD_W-1:0] n_r;
  logic [RAD_W-1:0] res_r;
  logic [RAD_W-1:0] bit_r;
  logic [RAD_W-1:0] trial;
  logic             fits;

  // Trial subtraction of the current candidate.
  assign trial = res_r + bit_r;
  assign fits  = (n_r >= trial);

  // One iteration per cycle, the test bit moving down two places each time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && (bit_r == RAD_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_r   <= radicand;
      res_r <= '0;
      bit_r <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy_r) begin
      if (fits) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[ROOT_W-1:0];

endmodule

[rtl/tilt_cordic.sv]
// Vectoring CORDIC arctangent, one micro-rotation per cycle, with rounding and
// saturation of the angle to centidegrees. Depends on tilt_pkg.
module tilt_cordic import tilt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic signed [CIN_W-1:0] y_in,
  input  logic signed [CIN_W-1:0] x_in,
  output cordic_rsp_t             rsp
);

  logic                   busy_r;
  logic                   done_r;
  logic                   zero_r;
  logic [CSTEP_W-1:0]     cnt_r;
  logic signed [CX_W-1:0] x_r;
  logic signed [CX_W-1:0] y_r;
  logic signed [CZ_W-1:0] z_r;
  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic signed [CX_W-1:0] xe;
  logic signed [CX_W-1:0] ye;
  logic signed [CZ_W-1:0] atan_v;
  logic signed [CZ_W-1:0] rnd;
  logic signed [ANG_W-1:0] sat;

  assign xe     = CX_W'(x_in);
  assign ye     = CX_W'(y_in);
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_v = atan_lut(5'(cnt_r));

  // Sequencing of the micro-rotations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CSTEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Datapath: a quarter-turn pre-rotation for the left half-plane, then the
  // usual add/subtract iterations driven by the sign of y.
  always_ff @(posedge clk) begin
    if (go) begin
      zero_r <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r <= ye;
          y_r <= -xe;
          z_r <= Z_QUARTER;
        end else begin
          x_r <= -ye;
          y_r <= xe;
          z_r <= -Z_QUARTER;
        end
      end else begin
        x_r <= xe;
        y_r <= ye;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end
  end

  // Round half up to centidegrees and clamp to half a turn.
  always_comb begin
    rnd = (z_r + 32'sd32768) >>> 16;
    if (rnd > ANG_LIMIT) begin
      sat = ANG_W'(ANG_LIMIT);
    end else if (rnd < -ANG_LIMIT) begin
      sat = ANG_W'(-ANG_LIMIT);
    end else begin
      sat = rnd[ANG_W-1:0];
    end
  end

  assign rsp.done  = done_r;
  assign rsp.angle = zero_r ? '0 : sat;

endmodule

[rtl/accel_reference_tilt_angles.sv]
// Top level of the accelerometer reference tilt angle block.
// Depends on tilt_pkg, tilt_if, tilt_sqrt and tilt_cordic.
//
// One vector is taken at a time; ready is low until its result has been
// loaded into the output register. With a gravity axis and no forward axis
// the three reference angles are computed one after another, each by one
// square root (one root bit per cycle) and one CORDIC arctangent of
// CORDIC_STEPS micro-rotations; these serial loops set the time that a
// vector takes. A zero vector or no gravity axis goes straight to the
// output stage, and the oriented mode copies the stored angles one axis
// per cycle.
module accel_reference_tilt_angles import tilt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tilt_in_if.sink               in_ch,
  tilt_out_if.source            out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_SQRT   = 6'b000100,
    ST_CORDIC = 6'b001000,
    ST_ORIENT = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state_r;
  logic [1:0] k_r;
  logic [1:0] mode_r;
  logic       status_r;
  logic       sqrt_go_r;
  logic       cordic_go_r;

  logic [1:0] grav_r;
  logic [1:0] fwd_r;
  logic [1:0] side_r;
  logic       fwd_neg_r;
  logic       side_neg_r;

  logic signed [ACC_W-1:0] a_r   [3];
  logic [SQ_W-1:0]         sq_r  [3];
  logic signed [ANG_W-1:0] ref_r [3];
  logic signed [ANG_W-1:0] ori_r [3];

  logic                    out_valid_r;
  logic signed [ANG_W-1:0] out_ang_r [3];
  logic [1:0]              out_mode_r;
  logic                    out_status_r;

  logic                    accept;
  logic signed [ACC_W-1:0] a_sel;
  logic signed [2*ACC_W-1:0] sq_full;
  logic [SQ_W-1:0]         sq_p;
  logic [SQ_W-1:0]         sq_q;
  logic [RAD_W-1:0]        radicand;
  logic signed [CIN_W-1:0] own;
  logic signed [CIN_W-1:0] nrm;
  logic signed [CIN_W-1:0] cy;
  logic signed [CIN_W-1:0] cx;
  logic [1:0]              ori_addr;
  logic                    ori_neg;
  logic signed [ANG_W-1:0] ori_src;
  logic signed [ANG_W-1:0] ori_val;
  logic                    out_free;
  sqrt_rsp_t               sqrt_rsp;
  cordic_rsp_t             cordic_rsp;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r     <= AXIS_NONE;
      fwd_r      <= AXIS_NONE;
      side_r     <= AXIS_Z;
      fwd_neg_r  <= 1'b0;
      side_neg_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAVITY:  grav_r     <= cfg_data;
        REG_FORWARD:  fwd_r      <= cfg_data;
        REG_SIDE:     side_r     <= cfg_data;
        REG_FWD_NEG:  fwd_neg_r  <= cfg_data[0];
        REG_SIDE_NEG: side_neg_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Component selection for the current axis and its two companions.
  always_comb begin
    case (k_r)
      2'd0:    begin a_sel = a_r[0]; sq_p = sq_r[1]; sq_q = sq_r[2]; end
      2'd1:    begin a_sel = a_r[1]; sq_p = sq_r[2]; sq_q = sq_r[0]; end
      default: begin a_sel = a_r[2]; sq_p = sq_r[0]; sq_q = sq_r[1]; end
    endcase
  end

  assign sq_full  = a_sel * a_sel;
  assign radicand = {32'(sq_p) + 32'(sq_q), 16'b0};
  assign own      = CIN_W'(a_sel) <<< 8;
  assign nrm      = $signed({1'b0, sqrt_rsp.root});
  assign cy       = (k_r == grav_r) ? nrm : own;
  assign cx       = (k_r == grav_r) ? own : nrm;

  // Oriented copy: gravity, then forward, then side.
  always_comb begin
    case (k_r)
      2'd0:    begin ori_addr = grav_r; ori_neg = 1'b0;       end
      2'd1:    begin ori_addr = fwd_r;  ori_neg = fwd_neg_r;  end
      default: begin ori_addr = side_r; ori_neg = side_neg_r; end
    endcase
    case (ori_addr)
      AXIS_X:  ori_src = ref_r[0];
      AXIS_Y:  ori_src = ref_r[1];
      default: ori_src = ref_r[2];
    endcase
    ori_val = ori_neg ? -ori_src : ori_src;
  end

  tilt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sqrt_go_r),
    .radicand (radicand),
    .rsp      (sqrt_rsp)
  );

  tilt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cordic_go_r),
    .y_in  (cy),
    .x_in  (cx),
    .rsp   (cordic_rsp)
  );

  // Sequencer and stored angles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      mode_r      <= MODE_NONE;
      status_r    <= 1'b0;
      sqrt_go_r   <= 1'b0;
      cordic_go_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ref_r[i] <= '0;
        ori_r[i] <= '0;
      end
    end else begin
      sqrt_go_r   <= 1'b0;
      cordic_go_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            k_r      <= '0;
            status_r <= 1'b0;
            a_r[0]   <= in_ch.accel_x;
            a_r[1]   <= in_ch.accel_y;
            a_r[2]   <= in_ch.accel_z;
            if (grav_r == AXIS_NONE) begin
              mode_r <= MODE_NONE;
              for (int i = 0; i < 3; i++) ref_r[i] <= '0;
              state_r <= ST_FIN;
            end else if (fwd_r == AXIS_NONE) begin
              mode_r <= MODE_GRAV;
              if ((in_ch.accel_x == '0) && (in_ch.accel_y == '0) &&
                  (in_ch.accel_z == '0)) begin
                status_r <= 1'b1;
                for (int i = 0; i < 3; i++) ref_r[i] <= '0;
                state_r <= ST_FIN;
              end else begin
                state_r <= ST_SQUARE;
              end
            end else begin
              mode_r  <= MODE_ORIENT;
              state_r <= ST_ORIENT;
            end
          end
        end
        ST_SQUARE: begin
          sq_r[k_r] <= sq_full[SQ_W-1:0];
          if (k_r == 2'd2) begin
            k_r       <= '0;
            sqrt_go_r <= 1'b1;
            state_r   <= ST_SQRT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_SQRT: begin
          if (sqrt_rsp.done) begin
            cordic_go_r <= 1'b1;
            state_r     <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cordic_rsp.done) begin
            ref_r[k_r] <= cordic_rsp.angle;
            if (k_r == 2'd2) begin
              state_r <= ST_FIN;
            end else begin
              k_r       <= k_r + 1'b1;
              sqrt_go_r <= 1'b1;
              state_r   <= ST_SQRT;
            end
          end
        end
        ST_ORIENT: begin
          if (ori_addr != AXIS_NONE) begin
            ori_r[ori_addr] <= ori_val;
          end
          if (k_r == 2'd2) begin
            state_r <= ST_FIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output payload, loaded as the transaction is offered.
  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      for (int i = 0; i < 3; i++) begin
        out_ang_r[i] <= (mode_r == MODE_ORIENT) ? ori_r[i] : ref_r[i];
      end
      out_mode_r   <= mode_r;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.angle_x = out_ang_r[0];
  assign out_ch.angle_y = out_ang_r[1];
  assign out_ch.angle_z = out_ang_r[2];
  assign out_ch.mode    = out_mode_r;
  assign out_ch.status  = out_status_r;

endmodule

[rtl/tilt_checker.sv]
// Port-level checker for the tilt angle block, bound to the top level.
// Depends on tilt_pkg and the assertion macro header.
`include "accel_reference_tilt_angles_macros.svh"

module tilt_checker import tilt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_mode,
  input logic       status
);

  // A pending result transaction stays offered.
  `TILT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // One vector at a time: after an accepted transaction the input closes.
  `TILT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // The zero-vector flag belongs only to the gravity-only mode.
  `TILT_ASSERT_NOW(a_status_mode, out_valid && status, out_mode == MODE_GRAV)

  // The mode field never carries the unused code.
  `TILT_ASSERT_NOW(a_mode_code, out_valid,
    (out_mode == MODE_NONE) || (out_mode == MODE_GRAV) || (out_mode == MODE_ORIENT))

endmodule

bind accel_reference_tilt_angles tilt_checker u_tilt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mode  (out_ch.mode),
  .status    (out_ch.status)
);

[test/accel_reference_tilt_angles_check.sv]
`timescale 1ns / 1ps
// Checker of the tilt angle block: tracks the register writes, predicts the angles of every
// accepted vector and compares them with the result transactions. Depends on tilt_pkg, tilt_if.
module accel_reference_tilt_angles_check import tilt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tilt_in_if                    in_ch,
  tilt_out_if                   out_ch,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic signed [ANG_W-1:0] ax;
    logic signed [ANG_W-1:0] ay;
    logic signed [ANG_W-1:0] az;
    logic [1:0]              mode;
    logic                    status;
  } tilt_result_t;

  // Arctangent of 2^-i in centidegrees scaled by 2^16.
  localparam longint ATAN_STEP [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45};

  tilt_result_t angle_queue[$];

  logic [1:0]              grav_sel, fwd_sel, side_sel;
  logic                    fwd_flip, side_flip;
  logic signed [ANG_W-1:0] ref_ang    [3];
  logic signed [ANG_W-1:0] orient_ang [3];

  // Floor of the square root, one result bit per pass.
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring arctangent in centidegrees, rounded half up and saturated.
  function automatic logic signed [ANG_W-1:0] arc_tangent(input longint y, input longint x);
    longint z, t, xs, ys;
    if (x == 0 && y == 0) return '0;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 589824000;
      end else begin
        t = x; x = -y; y = t; z = -589824000;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end
    end
    z = (z + 32768) >>> 16;
    if (z > 18000) z = 18000;
    if (z < -18000) z = -18000;
    return z[ANG_W-1:0];
  endfunction

  // Works out the result of one vector and updates the stored angles.
  function automatic tilt_result_t predict_angles(input logic signed [ACC_W-1:0] vx,
                                                  input logic signed [ACC_W-1:0] vy,
                                                  input logic signed [ACC_W-1:0] vz);
    tilt_result_t r;
    longint a [3];
    longint sq [3];
    longint nrm, own;
    logic signed [ANG_W-1:0] f, s;
    int p, q;
    r = '0;
    a[0] = vx; a[1] = vy; a[2] = vz;
    if (grav_sel == AXIS_NONE) begin
      r.mode = MODE_NONE;
      for (int k = 0; k < 3; k++) ref_ang[k] = '0;
    end else if (fwd_sel == AXIS_NONE) begin
      r.mode = MODE_GRAV;
      for (int k = 0; k < 3; k++) sq[k] = a[k] * a[k];
      if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
        r.status = 1'b1;
        for (int k = 0; k < 3; k++) ref_ang[k] = '0;
      end else begin
        for (int k = 0; k < 3; k++) begin
          p   = (k + 1) % 3;
          q   = (k + 2) % 3;
          nrm = longint'(root_floor(longint'(sq[p] + sq[q]) << 16));
          own = a[k] * 256;
          if (k == grav_sel) ref_ang[k] = arc_tangent(nrm, own);
          else               ref_ang[k] = arc_tangent(own, nrm);
        end
      end
      r.ax = ref_ang[0]; r.ay = ref_ang[1]; r.az = ref_ang[2];
    end else begin
      r.mode = MODE_ORIENT;
      f = ref_ang[fwd_sel];
      orient_ang[grav_sel] = ref_ang[grav_sel];
      orient_ang[fwd_sel]  = fwd_flip ? -f : f;
      if (side_sel != AXIS_NONE) begin
        s = ref_ang[side_sel];
        orient_ang[side_sel] = side_flip ? -s : s;
      end
      r.ax = orient_ang[0]; r.ay = orient_ang[1]; r.az = orient_ang[2];
    end
    return r;
  endfunction

  // Register writes, predictions on input transactions and checks on result transactions.
  always @(posedge clk) begin
    tilt_result_t got, want;
    if (!rst_n) begin
      grav_sel   <= AXIS_NONE;
      fwd_sel    <= AXIS_NONE;
      side_sel   <= AXIS_Z;
      fwd_flip   <= 1'b0;
      side_flip  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        ref_ang[k]    = '0;
        orient_ang[k] = '0;
      end
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRAVITY:  grav_sel  <= cfg_data;
          REG_FORWARD:  fwd_sel   <= cfg_data;
          REG_SIDE:     side_sel  <= cfg_data;
          REG_FWD_NEG:  fwd_flip  <= cfg_data[0];
          REG_SIDE_NEG: side_flip <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        angle_queue.push_back(predict_angles(in_ch.accel_x, in_ch.accel_y, in_ch.accel_z));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.angle_x, out_ch.angle_y, out_ch.angle_z, out_ch.mode, out_ch.status};
        if (angle_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = angle_queue.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      pending <= angle_queue.size();
    end
  end

endmodule

[test/accel_reference_tilt_angles_test.sv]
`timescale 1ns / 1ps
// Top of the tilt angle testbench: clock, reset, register writes, vector stimulus and the
// verdict. Depends on tilt_pkg, tilt_if, the block and accel_reference_tilt_angles_check.
module accel_reference_tilt_angles_test;
  import tilt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending;
  int                    items_sent = 0;
  int                    rx_taken = 0;
  int                    hold_left = 0;
  int                    cycles = 0;

  tilt_in_if  in_ch ();
  tilt_out_if out_ch ();

  accel_reference_tilt_angles uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  accel_reference_tilt_angles_check checker_inst (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    out_ch.ready  = 1'b0;
  end

  // Result side: random stalls, a calm stretch, and one long hold-off to fill the block.
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) rx_taken <= rx_taken + 1;
    if (in_ch.valid && in_ch.ready && rx_taken == 60) begin
      hold_left    <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_taken >= 200 && rx_taken < 300) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 29);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_axes(input logic [1:0] g, input logic [1:0] f, input logic [1:0] s,
                          input logic fn, input logic sn);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_FORWARD, f);
    write_reg(REG_SIDE, s);
    write_reg(REG_FWD_NEG, {1'b0, fn});
    write_reg(REG_SIDE_NEG, {1'b0, sn});
  endtask

  // Offers one vector and returns at the edge on which the transaction completes.
  task automatic send_vector(input logic signed [ACC_W-1:0] vx,
                             input logic signed [ACC_W-1:0] vy,
                             input logic signed [ACC_W-1:0] vz);
    while (!(items_sent >= 200 && items_sent < 300) && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= vx;
    in_ch.accel_y <= vy;
    in_ch.accel_z <= vz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every result is in, then lets the block settle before a register write.
  // The first edge lets the count of outstanding results take in the last transaction.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || (in_ch.valid && !in_ch.ready)) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [ACC_W-1:0] rand_component();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return ACC_W'($urandom);
    if (pick < 85) return ACC_W'($urandom_range(600) - 300);
    if (pick < 93) return '0;
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return '0;
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_vector(rand_component(), rand_component(), rand_component());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // No gravity axis after reset: zeros are returned.
    send_vector(16'sh8000, 16'sh7fff, 16'sd0);
    send_vector(16'sh7fff, 16'sh8000, -16'sd1);
    settle();

    // Gravity on z only: zero vector, extremes and the negative half planes.
    set_axes(AXIS_Z, AXIS_NONE, AXIS_Z, 1'b0, 1'b0);
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sh7fff);
    send_vector(16'sd0, 16'sd0, 16'sh8000);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(-16'sd1, 16'sd0, 16'sd0);
    send_vector(16'sd0, -16'sd1, 16'sd0);
    send_vector(16'sh8000, 16'sd0, 16'sd1);
    send_vector(16'sd300, -16'sd200, 16'sd16384);
    settle();

    // Oriented mode, plain then with repeated axes, then with no side axis and writes to unused indices.
    set_axes(AXIS_Z, AXIS_X, AXIS_Y, 1'b1, 1'b0);
    send_random(2);
    settle();
    set_axes(AXIS_Z, AXIS_Z, AXIS_Z, 1'b0, 1'b1);
    send_random(2);
    settle();
    write_reg(REG_SIDE, AXIS_NONE);
    write_reg(3'd5, 2'd3);
    write_reg(3'd7, 2'd1);
    send_random(2);
    settle();

    // Long random run with gravity on z; includes the calm stretch and the hold-off.
    set_axes(AXIS_Z, AXIS_NONE, AXIS_X, 1'b0, 1'b0);
    send_random(220);
    settle();
    set_axes(AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1);
    send_random(15);
    settle();

    // Gravity on x, then its oriented readout with negate values masked to one bit.
    set_axes(AXIS_X, AXIS_NONE, AXIS_Y, 1'b0, 1'b0);
    send_random(120);
    settle();
    write_reg(REG_FORWARD, AXIS_Y);
    write_reg(REG_SIDE, AXIS_Z);
    write_reg(REG_FWD_NEG, 2'd3);
    write_reg(REG_SIDE_NEG, 2'd2);
    send_random(10);
    settle();

    // Gravity on y, then a clear through no gravity axis and an oriented readout of zeros.
    set_axes(AXIS_Y, AXIS_NONE, AXIS_X, 1'b1, 1'b1);
    send_random(120);
    settle();
    set_axes(AXIS_Y, AXIS_X, AXIS_Z, 1'b0, 1'b1);
    send_random(8);
    settle();
    write_reg(REG_GRAVITY, AXIS_NONE);
    send_random(6);
    settle();
    write_reg(REG_GRAVITY, AXIS_Y);
    send_random(6);
    settle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
